// File: rtl/core/kvt_pkg.sv
`default_nettype none

package kvt_pkg;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;

   typedef enum logic [1:0] {
      MODE_SET    = 2'd0,
      MODE_GET    = 2'd1,
      MODE_DELETE = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type             mode;
      logic [KEY_W-1:0]     key;
      logic [VALUE_W-1:0]   value;
   } req_type;

   typedef struct packed {
      logic                 found;
      logic                 rejected;
      logic [VALUE_W-1:0]   read_value;
      logic [COUNT_W-1:0]   entry_count;
   } rsp_type;

   // Control part of the query token that walks the cell row.
   typedef struct packed {
      logic     valid;
      mode_type mode;
      logic     hit;
      logic     appended;
   } link_ctl_type;

endpackage

`default_nettype wire

// File: rtl/core/kvt_cell.sv
`default_nettype none

module kvt_cell
   import kvt_pkg::*;
#(
   parameter int INDEX      = 0,
   parameter int COUNT_BITS = 5,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [COUNT_BITS-1:0] pair_count,
   input  wire link_ctl_type          in_ctl,
   input  wire logic [KEY_BITS-1:0]   in_key,
   input  wire logic [VALUE_BITS-1:0] in_value,
   input  wire logic [VALUE_BITS-1:0] in_rdata,
   output link_ctl_type               out_ctl,
   output logic [KEY_BITS-1:0]        out_key,
   output logic [VALUE_BITS-1:0]      out_value,
   output logic [VALUE_BITS-1:0]      out_rdata,
   input  wire logic [KEY_BITS-1:0]   nbr_key,
   input  wire logic [VALUE_BITS-1:0] nbr_value,
   output logic [KEY_BITS-1:0]        own_key,
   output logic [VALUE_BITS-1:0]      own_value
);

   localparam logic [COUNT_BITS-1:0] INDEX_C = COUNT_BITS'(INDEX);

   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   link_ctl_type          link_ctl_ff, link_ctl_in;
   logic [KEY_BITS-1:0]   link_key_ff;
   logic [VALUE_BITS-1:0] link_value_ff;
   logic [VALUE_BITS-1:0] link_rdata_ff, link_rdata_in;

   logic occupied;
   logic match;
   logic shift;
   logic append;

   always_comb begin
      occupied = INDEX_C < pair_count;
      match    = in_ctl.valid && occupied && !in_ctl.hit &&
                 (in_ctl.mode != MODE_CLEAR) && (key_ff == in_key);
      // delete: from the hit slot onward pull the right neighbor's pair in
      shift    = in_ctl.valid && occupied && (in_ctl.mode == MODE_DELETE) &&
                 (match || in_ctl.hit);
      append   = in_ctl.valid && (in_ctl.mode == MODE_SET) && !in_ctl.hit &&
                 (pair_count == INDEX_C);

      key_in   = key_ff;
      value_in = value_ff;
      if (shift) begin
         key_in   = nbr_key;
         value_in = nbr_value;
      end else if (append) begin
         key_in   = in_key;
         value_in = in_value;
      end else if (match && (in_ctl.mode == MODE_SET)) begin
         value_in = in_value;
      end

      link_ctl_in          = in_ctl;
      link_ctl_in.hit      = in_ctl.hit | match;
      link_ctl_in.appended = in_ctl.appended | append;

      link_rdata_in = in_rdata;
      if (match && (in_ctl.mode == MODE_GET)) begin
         link_rdata_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      value_ff      <= value_in;
      link_key_ff   <= in_key;
      link_value_ff <= in_value;
      link_rdata_ff <= link_rdata_in;
      if (reset) begin
         link_ctl_ff <= '0;
      end else begin
         link_ctl_ff <= link_ctl_in;
      end
   end

   assign out_ctl   = link_ctl_ff;
   assign out_key   = link_key_ff;
   assign out_value = link_value_ff;
   assign out_rdata = link_rdata_ff;
   assign own_key   = key_ff;
   assign own_value = value_ff;

endmodule

`default_nettype wire

// File: rtl/core/key_value_table_top.sv
`default_nettype none

// Key-value table with unique keys, held in a row of CAPACITY cells.
// Command channel: drive req_data and raise start; the beat is taken at the
// clock edge where start is high and busy is low. req_data.mode selects
// set, get, delete or clear.
// Result channel: rsp_valid is high for exactly one cycle with rsp_data
// (found, rejected, read_value, entry_count). The receiver cannot stall it;
// a result not sampled in that cycle is gone.
// Timing: a query token walks the cell row one cell per cycle. Each cell
// registers the token, and rsp_valid is registered from the token leaving
// the last cell. busy stays high from the accepting edge until the token
// leaves the row, so a new command is taken only once the previous one is
// through; the row length alone sets how long busy stays high.
// Delete closes the gap by shifting the following pairs down one cell as
// the token passes. A set of a new key on a full table is flagged rejected.
// Reset: the pair count goes to zero and no token is in flight; the pair
// storage is not cleared, since cells at or above the count never match.

module key_value_table_top
   import kvt_pkg::*;
#(
   parameter int CAPACITY   = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam int COUNT_BITS = $clog2(CAPACITY + 1);
   localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(CAPACITY);

   // Token links between cells; link i feeds cell i.
   link_ctl_type          ctl_link   [CAPACITY+1];
   logic [KEY_BITS-1:0]   key_link   [CAPACITY+1];
   logic [VALUE_BITS-1:0] value_link [CAPACITY+1];
   logic [VALUE_BITS-1:0] rdata_link [CAPACITY+1];

   // Stored pairs as seen by the left neighbor (delete shift path).
   logic [KEY_BITS-1:0]   store_key   [CAPACITY];
   logic [VALUE_BITS-1:0] store_value [CAPACITY];

   logic [CAPACITY-1:0]   tok_valid;

   logic                  busy_ff, busy_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff, rsp_data_in;
   logic                  accept;
   link_ctl_type          tail;

   assign accept = start && !busy_ff;

   // Inject the query at the head of the row in the accepting cycle.
   always_comb begin
      ctl_link[0].valid    = accept;
      ctl_link[0].mode     = req_data.mode;
      ctl_link[0].hit      = 1'b0;
      ctl_link[0].appended = 1'b0;
   end
   assign key_link[0]   = KEY_BITS'(req_data.key);
   assign value_link[0] = VALUE_BITS'(req_data.value);
   assign rdata_link[0] = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_BITS-1:0]   nbr_key;
      logic [VALUE_BITS-1:0] nbr_value;

      if (i == CAPACITY - 1) begin : g_last
         // Nothing beyond the last cell; it only ever drops out of the count.
         assign nbr_key   = store_key[i];
         assign nbr_value = store_value[i];
      end else begin : g_mid
         assign nbr_key   = store_key[i+1];
         assign nbr_value = store_value[i+1];
      end

      kvt_cell #(
         .INDEX      (i),
         .COUNT_BITS (COUNT_BITS),
         .KEY_BITS   (KEY_BITS),
         .VALUE_BITS (VALUE_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .pair_count (count_ff),
         .in_ctl     (ctl_link[i]),
         .in_key     (key_link[i]),
         .in_value   (value_link[i]),
         .in_rdata   (rdata_link[i]),
         .out_ctl    (ctl_link[i+1]),
         .out_key    (key_link[i+1]),
         .out_value  (value_link[i+1]),
         .out_rdata  (rdata_link[i+1]),
         .nbr_key    (nbr_key),
         .nbr_value  (nbr_value),
         .own_key    (store_key[i]),
         .own_value  (store_value[i])
      );

      assign tok_valid[i] = ctl_link[i+1].valid;
   end

   assign tail = ctl_link[CAPACITY];

   // Settle the count and build the result when the token leaves the row.
   always_comb begin
      count_in = count_ff;
      if (tail.valid) begin
         case (tail.mode)
            MODE_CLEAR:  count_in = '0;
            MODE_SET:    if (tail.appended) count_in = count_ff + 1'b1;
            MODE_DELETE: if (tail.hit) count_in = count_ff - 1'b1;
            default:     count_in = count_ff;
         endcase
      end

      rsp_data_in.found       = tail.hit;
      rsp_data_in.rejected    = (tail.mode == MODE_SET) && !tail.hit && !tail.appended;
      rsp_data_in.read_value  = VALUE_W'(rdata_link[CAPACITY]);
      rsp_data_in.entry_count = COUNT_W'(count_in);

      // Hold busy from the accepting edge until the token drops out.
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (tail.valid) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= tail.valid;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("pair count above capacity");

   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_valid))
      else $error("more than one token in the cell row");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("busy not raised after accepted beat");

   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy_ff || $past(accept))
      else $error("result shown while an item is in flight");

   a_reject_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.rejected |-> count_ff == FULL_COUNT)
      else $error("set rejected on a table that is not full");
`endif

endmodule

`default_nettype wire
